// ===== rtl/rcp_pkg.sv =====
// Shared types, constants and the cookie prefix table for the connection request parser.
`default_nettype none
package rcp_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [2:0] ST_OK_TOKEN   = 3'd0;
  localparam logic [2:0] ST_OK_NOTOKEN = 3'd1;
  localparam logic [2:0] ST_BAD_VER    = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd3;
  localparam logic [2:0] ST_BAD_X224   = 3'd4;
  localparam logic [2:0] ST_BAD_NEGREQ = 3'd5;

  localparam logic KIND_TOKEN   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0]  TPKT_VERSION = 8'h03;
  localparam logic [7:0]  X224_CR_CODE = 8'hE0;
  localparam logic [7:0]  CLASS_MASK   = 8'hFC;
  localparam logic [7:0]  NEG_TYPE_REQ = 8'h01;
  localparam logic [7:0]  NEG_LEN_LO   = 8'h08;
  localparam logic [7:0]  RDSTLS_MASK  = 8'h04;
  localparam logic [7:0]  CHAR_CR      = 8'h0D;
  localparam logic [7:0]  CHAR_LF      = 8'h0A;
  localparam logic [15:0] HDR_LEN      = 16'd11;
  localparam logic [15:0] PREFIX_LAST  = 16'd23;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic        rdstls;
    logic [15:0] token_len;
    logic        last;
  } rcp_result_t;

  // front -> queue write request
  typedef struct packed {
    logic        valid;
    logic        two;
    rcp_result_t r0;
    rcp_result_t r1;
  } rcp_push_t;

  function automatic logic [7:0] cookie_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6F; // o
      4'd3:    c = 8'h6B; // k
      4'd4:    c = 8'h69; // i
      4'd5:    c = 8'h65; // e
      4'd6:    c = 8'h3A; // :
      4'd7:    c = 8'h20; // space
      4'd8:    c = 8'h6D; // m
      4'd9:    c = 8'h73; // s
      4'd10:   c = 8'h74; // t
      4'd11:   c = 8'h73; // s
      4'd12:   c = 8'h3D; // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rdp_connection_request_parser_top.sv =====
// Each result is queued as its byte is accepted, then moved into the output register.
// Throughput: one byte per cycle while the queue has room; the output drains one result
//   per cycle while out_ready_i is high; a byte that releases a held CR adds a second result.
// A four-entry result queue decouples the parser from the output register.
// Reset (rst_ni low, asynchronous): parser idle awaiting a first byte, queue and output empty.
`default_nettype none
module rdp_connection_request_parser_top
  import rcp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       data_out_o,
  output logic [2:0]       status_o,
  output logic             rdstls_requested_o,
  output logic [15:0]      token_length_o,
  output logic             last_o
);

  rcp_push_t   push;
  rcp_result_t head;
  rcp_result_t res;
  logic        space, nonempty, pop;

  assign in_ready_o = space;

  rcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_valid_i && space),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .push_o       (push)
  );

  rcp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_o    (space),
    .nonempty_o (nonempty),
    .head_o     (head),
    .pop_i      (pop)
  );

  rcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res)
  );

  assign kind_o             = res.kind;
  assign data_out_o         = res.data;
  assign status_o           = res.status;
  assign rdstls_requested_o = res.rdstls;
  assign token_length_o     = res.token_len;
  assign last_o             = res.last;

endmodule
`default_nettype wire

// ===== rtl/rcp_front.sv =====
// Byte parser: header checks, cookie prefix match, token streaming and rdpNegReq checks.
`default_nettype none
module rcp_front
  import rcp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic      first_byte_i,
  output rcp_push_t      push_o
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HDR     = 3'd1;
  localparam logic [2:0] PH_PREFIX  = 3'd2;
  localparam logic [2:0] PH_NOTOKEN = 3'd3;
  localparam logic [2:0] PH_TOKEN   = 3'd4;
  localparam logic [2:0] PH_NEG     = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] byte_index_q, byte_index_d;
  logic [15:0] pdu_length_q, pdu_length_d;
  logic [15:0] token_count_q, token_count_d;
  logic        cr_pending_q, cr_pending_d;
  logic        neg_ok_q, neg_ok_d;
  logic        rdstls_q, rdstls_d;
  logic [2:0]  neg_off_q, neg_off_d;

  logic [2:0]  ph;
  logic [15:0] idx, pl, tc;
  logic        crp, nok, rb;
  logic [2:0]  noff;
  logic        active, at_end;
  logic        verdict;
  logic [2:0]  v_status;
  logic        v_rdstls;
  logic [15:0] v_len;
  logic        tok0, tok1;
  logic [7:0]  tok0_data, tok1_data;
  logic [7:0]  b;
  logic [4:0]  pre_pos;
  rcp_result_t r0, r1;

  assign b = data_byte_i;

  always_comb begin
    pre_pos = 5'd0;
    if (first_byte_i) begin
      ph   = PH_HDR;
      idx  = 16'd0;
      pl   = 16'd0;
      tc   = 16'd0;
      crp  = 1'b0;
      nok  = 1'b1;
      rb   = 1'b0;
      noff = 3'd0;
    end else begin
      ph   = phase_q;
      idx  = byte_index_q + 16'd1;
      pl   = pdu_length_q;
      tc   = token_count_q;
      crp  = cr_pending_q;
      nok  = neg_ok_q;
      rb   = rdstls_q;
      noff = neg_off_q;
    end
    active = accept_i && (first_byte_i || (phase_q != PH_IDLE));
    at_end = ((ph != PH_HDR) || (idx >= 16'd3)) &&
             (({1'b0, idx} + 17'd1) == {1'b0, pl});

    phase_d       = ph;
    pdu_length_d  = pl;
    cr_pending_d  = crp;
    neg_ok_d      = nok;
    rdstls_d      = rb;
    neg_off_d     = noff;
    verdict       = 1'b0;
    v_status      = ST_OK_NOTOKEN;
    v_rdstls      = 1'b0;
    v_len         = 16'd0;
    tok0          = 1'b0;
    tok1          = 1'b0;
    tok0_data     = 8'h00;
    tok1_data     = 8'h00;

    unique case (ph)
      PH_HDR: begin
        if (idx == 16'd2) pdu_length_d = {b, 8'h00};
        if (idx == 16'd3) pdu_length_d = pl | {8'h00, b};
        priority if (idx == 16'd0 && b != TPKT_VERSION) begin
          verdict  = 1'b1;
          v_status = ST_BAD_VER;
        end else if (idx == 16'd3 && ((pl | {8'h00, b}) < HDR_LEN)) begin
          verdict  = 1'b1;
          v_status = ST_TOO_SHORT;
        end else if (idx == 16'd4 && ({9'd0, b} + 17'd5) != {1'b0, pl}) begin
          verdict  = 1'b1;
          v_status = ST_BAD_X224;
        end else if (idx == 16'd5 && b != X224_CR_CODE) begin
          verdict  = 1'b1;
          v_status = ST_BAD_X224;
        end else if ((idx == 16'd6 || idx == 16'd7) && b != 8'h00) begin
          verdict  = 1'b1;
          v_status = ST_BAD_X224;
        end else if (idx == 16'd10 && (b & CLASS_MASK) != 8'h00) begin
          verdict  = 1'b1;
          v_status = ST_BAD_X224;
        end else if (idx == 16'd10) begin
          if (at_end) begin
            verdict  = 1'b1;
            v_status = ST_OK_NOTOKEN;
          end else begin
            phase_d = PH_PREFIX;
          end
        end else begin
          phase_d = PH_HDR;
        end
        if (verdict) phase_d = PH_IDLE;
      end
      PH_PREFIX: begin
        pre_pos = idx[4:0] - HDR_LEN[4:0];
        if (b != cookie_char(pre_pos[3:0])) phase_d = PH_NOTOKEN;
        else if (idx == PREFIX_LAST) phase_d = PH_TOKEN;
        if (at_end) begin
          phase_d = PH_IDLE;
          verdict = 1'b1;
        end
      end
      PH_NOTOKEN: begin
        if (at_end) begin
          phase_d = PH_IDLE;
          verdict = 1'b1;
        end
      end
      PH_TOKEN: begin
        if (crp && b == CHAR_LF) begin
          cr_pending_d = 1'b0;
          neg_off_d    = 3'd0;
          // room for a full rdpNegReq after the LF?
          phase_d = ({1'b0, pl} >= ({1'b0, idx} + 17'd9)) ? PH_NEG : PH_SKIP;
          if (at_end) begin
            phase_d  = PH_IDLE;
            verdict  = 1'b1;
            v_status = ST_OK_TOKEN;
            v_len    = tc;
          end
        end else if (at_end) begin
          phase_d = PH_IDLE;
          verdict = 1'b1;
        end else if (crp) begin
          tok0      = 1'b1;
          tok0_data = CHAR_CR;
          if (b != CHAR_CR) begin
            cr_pending_d = 1'b0;
            tok1         = 1'b1;
            tok1_data    = b;
          end
        end else if (b == CHAR_CR) begin
          cr_pending_d = 1'b1;
        end else begin
          tok0      = 1'b1;
          tok0_data = b;
        end
      end
      PH_NEG: begin
        if (noff == 3'd0 && b != NEG_TYPE_REQ) neg_ok_d = 1'b0;
        if (noff == 3'd2 && b != NEG_LEN_LO) neg_ok_d = 1'b0;
        if (noff == 3'd3 && b != 8'h00) neg_ok_d = 1'b0;
        if (noff == 3'd4) rdstls_d = (b & RDSTLS_MASK) != 8'h00;
        if (noff != 3'd7) neg_off_d = noff + 3'd1;
        if (at_end) begin
          phase_d  = PH_IDLE;
          verdict  = 1'b1;
          v_len    = tc;
          v_status = neg_ok_d ? ST_OK_TOKEN : ST_BAD_NEGREQ;
          v_rdstls = neg_ok_d & rdstls_d;
        end
      end
      PH_SKIP: begin
        if (at_end) begin
          phase_d  = PH_IDLE;
          verdict  = 1'b1;
          v_status = ST_OK_TOKEN;
          v_len    = tc;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    byte_index_d  = idx;
    token_count_d = tc + {15'd0, tok0} + {15'd0, tok1};

    r0 = '0;
    r1 = '0;
    if (verdict) begin
      r0.kind      = KIND_VERDICT;
      r0.status    = v_status;
      r0.rdstls    = v_rdstls;
      r0.token_len = v_len;
      r0.last      = 1'b1;
    end else begin
      r0.kind   = KIND_TOKEN;
      r0.data   = tok0_data;
      r0.status = ST_OK_TOKEN;
      r0.last   = !tok1;
      r1.kind   = KIND_TOKEN;
      r1.data   = tok1_data;
      r1.status = ST_OK_TOKEN;
      r1.last   = 1'b1;
    end
  end

  assign push_o.valid = active && (verdict || tok0);
  assign push_o.two   = active && tok1;
  assign push_o.r0    = r0;
  assign push_o.r1    = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      byte_index_q  <= '0;
      pdu_length_q  <= '0;
      token_count_q <= '0;
      cr_pending_q  <= 1'b0;
      neg_ok_q      <= 1'b1;
      rdstls_q      <= 1'b0;
      neg_off_q     <= '0;
    end else if (active) begin
      phase_q       <= phase_d;
      byte_index_q  <= byte_index_d;
      pdu_length_q  <= pdu_length_d;
      token_count_q <= token_count_d;
      cr_pending_q  <= cr_pending_d;
      neg_ok_q      <= neg_ok_d;
      rdstls_q      <= rdstls_d;
      neg_off_q     <= neg_off_d;
    end
  end

  // two results per byte only ever come from a released CR plus the next byte
  a_two_are_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.two |-> push_o.valid && push_o.r0.kind == KIND_TOKEN &&
                   push_o.r1.kind == KIND_TOKEN && push_o.r0.data == CHAR_CR)
    else $error("double push without held CR");

  // after a verdict the parser is idle until the next first byte
  a_idle_after_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.r0.kind == KIND_VERDICT) |=> phase_q == PH_IDLE)
    else $error("parser not idle after verdict");

endmodule
`default_nettype wire

// ===== rtl/rcp_queue.sv =====
// Small result queue between parser and output stage; takes up to two entries per cycle.
`default_nettype none
module rcp_queue
  import rcp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rcp_push_t push_i,
  output logic           space_o,
  output logic           nonempty_o,
  output rcp_result_t    head_o,
  input  wire logic      pop_i
);

  rcp_result_t           mem_q [QDepth];
  logic [QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]      count_q, count_d;
  logic [QPtrW-1:0]      wr_ptr_next;
  logic [QCntW-1:0]      n_push;

  assign wr_ptr_next = wr_ptr_q + QPtrW'(1);
  assign n_push      = QCntW'(push_i.valid) + QCntW'(push_i.two);
  // room for the worst case of two entries
  assign space_o     = count_q <= QCntW'(QDepth - 2);
  assign nonempty_o  = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(n_push);
    rd_ptr_d = pop_i ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q + n_push - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.two) mem_q[wr_ptr_next] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> count_q <= QCntW'(QDepth - 2))
    else $error("push into queue without room");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_count_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth) &&
    QPtrW'(count_q) == QPtrW'(wr_ptr_q - rd_ptr_q))
    else $error("queue count out of step with pointers");

endmodule
`default_nettype wire

// ===== rtl/rcp_back.sv =====
// Output register stage: pulls results from the queue and holds them until transferred.
`default_nettype none
module rcp_back
  import rcp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        nonempty_i,
  input  wire rcp_result_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rcp_result_t      result_o
);

  logic        valid_q;
  rcp_result_t res_q;

  assign pop_o       = nonempty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign result_o    = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= nonempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= head_i;
  end

endmodule
`default_nettype wire

// ===== tb/rdp_connection_request_parser_checker.sv =====
// Checker: predicts token bytes and verdicts from accepted bytes and compares the outputs.
module rdp_connection_request_parser_checker
  import rcp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              kind_i,
  input  logic [7:0]        data_out_i,
  input  logic [2:0]        status_i,
  input  logic              rdstls_requested_i,
  input  logic [15:0]       token_length_i,
  input  logic              last_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [103:0] CookieBytes  = "Cookie: msts=";
  localparam int unsigned  CookieLen    = 13;
  // first rdpNegReq byte sits after header, prefix, token and CR LF
  localparam int unsigned  NegReqBase   = 11 + CookieLen + 2;
  localparam int unsigned  NegReqLen    = 8;
  localparam int unsigned  ReportLimit  = 10;

  typedef enum logic [3:0] {
    P_IDLE, P_HEADER, P_COOKIE, P_NO_COOKIE, P_TOKEN, P_NEGREQ, P_TAIL
  } parse_phase_e;

  parse_phase_e ph;
  logic [15:0]  pos;
  logic [15:0]  total_len;
  logic [15:0]  tok_cnt;
  logic         held_cr;
  logic         neg_ok;
  logic         rdstls_seen;
  int unsigned  emitted;

  rcp_result_t  expected_results[$];
  rcp_result_t  want;
  rcp_result_t  seen;

  function automatic void clear_parser();
    ph          = P_IDLE;
    pos         = '0;
    total_len   = '0;
    tok_cnt     = '0;
    held_cr     = 1'b0;
    neg_ok      = 1'b1;
    rdstls_seen = 1'b0;
  endfunction

  function automatic void emit(input logic k, input logic [7:0] d, input logic [2:0] st,
                               input logic rd, input logic [15:0] len);
    rcp_result_t r;
    r.kind      = k;
    r.data      = d;
    r.status    = st;
    r.rdstls    = rd;
    r.token_len = len;
    r.last      = 1'b0;
    expected_results.push_back(r);
    emitted++;
  endfunction

  function automatic void stream_token(input logic [7:0] b);
    emit(KIND_TOKEN, b, ST_OK_TOKEN, 1'b0, 16'd0);
    tok_cnt = tok_cnt + 16'd1;
  endfunction

  function automatic void verdict(input logic [2:0] st, input logic rd, input logic [15:0] len);
    ph = P_IDLE;
    emit(KIND_VERDICT, 8'h00, st, rd, len);
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic sop);
    logic [15:0] idx;
    logic        at_end;
    int unsigned k;
    int unsigned off;
    emitted = 0;
    if (sop) begin
      clear_parser();
      ph = P_HEADER;
    end else if (ph == P_IDLE) begin
      return;
    end else begin
      pos = pos + 16'd1;
    end
    idx = pos;
    at_end = (ph != P_HEADER || idx >= 16'd3) && (32'(idx) + 32'd1 == 32'(total_len));

    case (ph)
      P_HEADER: begin
        case (idx)
          16'd0: if (b != TPKT_VERSION) verdict(ST_BAD_VER, 1'b0, 16'd0);
          16'd2: total_len = {b, 8'h00};
          16'd3: begin
            total_len = total_len | {8'h00, b};
            if (total_len < HDR_LEN) verdict(ST_TOO_SHORT, 1'b0, 16'd0);
          end
          16'd4: if (32'(b) + 32'd5 != 32'(total_len)) verdict(ST_BAD_X224, 1'b0, 16'd0);
          16'd5: if (b != X224_CR_CODE) verdict(ST_BAD_X224, 1'b0, 16'd0);
          16'd6, 16'd7: if (b != 8'h00) verdict(ST_BAD_X224, 1'b0, 16'd0);
          16'd10: begin
            if ((b & CLASS_MASK) != 8'h00) verdict(ST_BAD_X224, 1'b0, 16'd0);
            else if (at_end) verdict(ST_OK_NOTOKEN, 1'b0, 16'd0);
            else ph = P_COOKIE;
          end
          default: ;
        endcase
      end
      P_COOKIE: begin
        k = int'(idx) - 11;
        if (b != CookieBytes[103 - 8 * k -: 8]) ph = P_NO_COOKIE;
        else if (k == CookieLen - 1) ph = P_TOKEN;
        if (at_end) verdict(ST_OK_NOTOKEN, 1'b0, 16'd0);
      end
      P_NO_COOKIE: begin
        if (at_end) verdict(ST_OK_NOTOKEN, 1'b0, 16'd0);
      end
      P_TOKEN: begin
        if (held_cr && b == CHAR_LF) begin
          held_cr = 1'b0;
          ph = (32'(total_len) - 32'd1 - 32'(idx) >= NegReqLen) ? P_NEGREQ : P_TAIL;
          if (at_end) verdict(ST_OK_TOKEN, 1'b0, tok_cnt);
        end else if (at_end) begin
          // PDU ended before CR LF: streamed bytes are void
          verdict(ST_OK_NOTOKEN, 1'b0, 16'd0);
        end else if (held_cr) begin
          stream_token(CHAR_CR);
          if (b != CHAR_CR) begin
            held_cr = 1'b0;
            stream_token(b);
          end
        end else if (b == CHAR_CR) begin
          held_cr = 1'b1;
        end else begin
          stream_token(b);
        end
      end
      P_NEGREQ: begin
        off = 32'(idx) - (32'(tok_cnt) + NegReqBase);
        if (off == 0 && b != NEG_TYPE_REQ) neg_ok = 1'b0;
        if (off == 2 && b != NEG_LEN_LO) neg_ok = 1'b0;
        if (off == 3 && b != 8'h00) neg_ok = 1'b0;
        if (off == 4) rdstls_seen = ((b & RDSTLS_MASK) != 8'h00);
        if (at_end) begin
          if (neg_ok) verdict(ST_OK_TOKEN, rdstls_seen, tok_cnt);
          else verdict(ST_BAD_NEGREQ, 1'b0, tok_cnt);
        end
      end
      P_TAIL: begin
        if (at_end) verdict(ST_OK_TOKEN, 1'b0, tok_cnt);
      end
      default: ph = P_IDLE;
    endcase

    if (emitted > 0) expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  task automatic report(input string what);
    mismatch_count_o++;
    if (mismatch_count_o <= ReportLimit)
      $display("%0t: %s: exp kind %0d data %02h st %0d rdstls %0d len %0d last %0d",
               $realtime, what, want.kind, want.data, want.status, want.rdstls,
               want.token_len, want.last);
    if (mismatch_count_o <= ReportLimit)
      $display("%0t: %s: got kind %0d data %02h st %0d rdstls %0d len %0d last %0d",
               $realtime, what, seen.kind, seen.data, seen.status, seen.rdstls,
               seen.token_len, seen.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // output side first: results of this edge's input appear only later
      if (out_valid_i && out_ready_i) begin
        seen.kind      = kind_i;
        seen.data      = data_out_i;
        seen.status    = status_i;
        seen.rdstls    = rdstls_requested_i;
        seen.token_len = token_length_i;
        seen.last      = last_i;
        if (expected_results.size() == 0) begin
          want = '0;
          report("unexpected result");
        end else begin
          want = expected_results.pop_front();
          if (want !== seen) report("result mismatch");
        end
      end
      if (in_valid_i && in_ready_i) parse_byte(data_byte_i, first_byte_i);
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== tb/rdp_connection_request_parser_top_tb.sv =====
// Testbench top: feeds connection request PDUs to the parser and reports the verdict.
module rdp_connection_request_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcp_pkg::*;

  localparam logic [103:0] CookieBytes = "Cookie: msts=";
  localparam int unsigned  CookieLen   = 13;
  localparam int unsigned  StimBytes   = 1100;
  localparam int unsigned  HoldCycles  = 400;
  localparam int unsigned  DrainCycles = 16;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i  = 8'h00;
  logic        first_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        kind_o;
  logic [7:0]  data_out_o;
  logic [2:0]  status_o;
  logic        rdstls_requested_o;
  logic [15:0] token_length_o;
  logic        last_o;

  int unsigned mismatches;
  int unsigned pending;

  logic [7:0]  pay_q[$];
  logic [7:0]  pdu_q[$];
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned rand_pdus  = 0;
  logic        hold_req   = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rdp_connection_request_parser_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .first_byte_i       (first_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .data_out_o         (data_out_o),
    .status_o           (status_o),
    .rdstls_requested_o (rdstls_requested_o),
    .token_length_o     (token_length_o),
    .last_o             (last_o)
  );

  rdp_connection_request_parser_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .first_byte_i       (first_byte_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_i             (kind_o),
    .data_out_i         (data_out_o),
    .status_i           (status_o),
    .rdstls_requested_i (rdstls_requested_o),
    .token_length_i     (token_length_o),
    .last_i             (last_o),
    .mismatch_count_o   (mismatches),
    .pending_o          (pending)
  );

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_byte(input logic [7:0] b, input logic sop);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (hold_req) gap = 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    first_byte_i <= sop;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_pdu(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) send_byte(pdu_q[k], k == 0);
  endtask

  task automatic add_cookie(input int unsigned upto);
    for (int unsigned k = 0; k < upto; k++) pay_q.push_back(CookieBytes[103 - 8 * k -: 8]);
  endtask

  task automatic add_random(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) pay_q.push_back(8'($urandom));
  endtask

  task automatic add_crlf();
    pay_q.push_back(CHAR_CR);
    pay_q.push_back(CHAR_LF);
  endtask

  // token content leans on CR and LF but never closes itself with CR LF
  task automatic add_token(input int unsigned n);
    logic [7:0] b;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       b = CHAR_CR;
        1:       b = CHAR_LF;
        default: b = 8'($urandom);
      endcase
      if (b == CHAR_LF && pay_q.size() != 0 && pay_q[pay_q.size() - 1] == CHAR_CR) b = 8'h2E;
      pay_q.push_back(b);
    end
  endtask

  task automatic add_negreq(input logic [7:0] typ, input logic [7:0] len_lo,
                            input logic [7:0] len_hi, input logic [7:0] proto);
    pay_q.push_back(typ);
    pay_q.push_back(8'($urandom));  // flags
    pay_q.push_back(len_lo);
    pay_q.push_back(len_hi);
    pay_q.push_back(proto);
    add_random(3);
  endtask

  // well-formed TPKT + X.224 CR header around pay_q
  task automatic wrap_header();
    logic [15:0] total;
    total = 16'(11 + pay_q.size());
    pdu_q.delete();
    pdu_q.push_back(TPKT_VERSION);
    pdu_q.push_back(8'($urandom));
    pdu_q.push_back(total[15:8]);
    pdu_q.push_back(total[7:0]);
    pdu_q.push_back(8'(total - 16'd5));
    pdu_q.push_back(X224_CR_CODE);
    pdu_q.push_back(8'h00);
    pdu_q.push_back(8'h00);
    pdu_q.push_back(8'($urandom));
    pdu_q.push_back(8'($urandom));
    pdu_q.push_back(8'($urandom_range(0, 3)));
    foreach (pay_q[k]) pdu_q.push_back(pay_q[k]);
  endtask

  task automatic break_header();
    case ($urandom_range(0, 6))
      0: pdu_q[0] = pdu_q[0] ^ 8'($urandom_range(1, 255));
      1: begin
        pdu_q[2] = 8'h00;
        pdu_q[3] = 8'($urandom_range(0, 10));
      end
      2: pdu_q[2] = 8'($urandom_range(1, 255));
      3: pdu_q[4] = pdu_q[4] ^ 8'($urandom_range(1, 255));
      4: pdu_q[5] = pdu_q[5] ^ 8'($urandom_range(1, 255));
      5: pdu_q[6 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
      default: pdu_q[10] = pdu_q[10] | 8'(1 << $urandom_range(2, 7));
    endcase
  endtask

  task automatic random_pdu();
    int unsigned sel;
    int unsigned tok_len;
    int unsigned n;
    logic        broken;
    pay_q.delete();
    sel = $urandom_range(0, 99);
    tok_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    if (sel < 60) begin
      add_cookie(CookieLen);
      add_token(tok_len);
      add_crlf();
      if ($urandom_range(0, 3) != 0) begin
        add_negreq(($urandom_range(0, 7) == 0) ? 8'($urandom) : NEG_TYPE_REQ,
                   ($urandom_range(0, 7) == 0) ? 8'($urandom) : NEG_LEN_LO,
                   ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                   8'($urandom));
        add_random($urandom_range(0, 3));
      end else begin
        add_random($urandom_range(0, 7));
      end
    end else if (sel < 72) begin
      add_cookie(CookieLen);
      add_token(tok_len);
      if ($urandom_range(0, 1) == 1) pay_q.push_back(CHAR_CR);
    end else if (sel < 84) begin
      add_cookie($urandom_range(0, CookieLen - 1));
      add_random($urandom_range(1, 20));
    end else begin
      add_random($urandom_range(0, 30));
    end
    wrap_header();
    broken = ($urandom_range(0, 4) == 0);
    if (broken) break_header();
    n = pdu_q.size();
    if (broken) n = 11 + $urandom_range(0, 4);
    else if ($urandom_range(0, 19) == 0) n = $urandom_range(1, n - 1);  // cut short
    if (n > pdu_q.size()) n = pdu_q.size();
    send_pdu(n);
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    rand_pdus++;
  endtask

  // Receiver: ready patterns, plus a long hold-off on request.
  initial begin
    int unsigned mode;
    int unsigned left;
    mode = 0;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 150);
        end
        left--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes while idle are dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    // minimum length, no payload
    pay_q.delete();
    wrap_header();
    send_pdu(pdu_q.size());

    // every header fault
    for (int f = 0; f < 8; f++) begin
      pay_q.delete();
      add_cookie(CookieLen);
      wrap_header();
      case (f)
        0: pdu_q[0] = 8'h00;
        1: pdu_q[0] = 8'hFF;
        2: begin
          pdu_q[2] = 8'h00;
          pdu_q[3] = 8'd10;
        end
        3: begin
          pdu_q[2] = 8'hFF;
          pdu_q[3] = 8'hFF;
        end
        4: pdu_q[5] = 8'h00;
        5: pdu_q[6] = 8'hFF;
        6: pdu_q[7] = 8'h01;
        default: pdu_q[10] = 8'hFF;
      endcase
      send_pdu(pdu_q.size());
    end

    // token with lone CRs, full rdpNegReq asking for RDSTLS
    pay_q.delete();
    add_cookie(CookieLen);
    pay_q.push_back(8'h61);
    pay_q.push_back(CHAR_CR);
    pay_q.push_back(CHAR_CR);
    pay_q.push_back(8'h78);
    pay_q.push_back(8'hFF);
    pay_q.push_back(8'h00);
    add_crlf();
    add_negreq(NEG_TYPE_REQ, NEG_LEN_LO, 8'h00, 8'h0F);
    wrap_header();
    send_pdu(pdu_q.size());

    // empty token, PDU ends on the LF
    pay_q.delete();
    add_cookie(CookieLen);
    add_crlf();
    wrap_header();
    send_pdu(pdu_q.size());

    // fewer than 8 bytes after CR LF
    pay_q.delete();
    add_cookie(CookieLen);
    pay_q.push_back(8'h7A);
    add_crlf();
    add_random(3);
    wrap_header();
    send_pdu(pdu_q.size());

    // bad rdpNegReq type, then bad length high byte
    pay_q.delete();
    add_cookie(CookieLen);
    pay_q.push_back(8'h71);
    add_crlf();
    add_negreq(8'h02, NEG_LEN_LO, 8'h00, 8'h04);
    wrap_header();
    send_pdu(pdu_q.size());
    pay_q.delete();
    add_cookie(CookieLen);
    add_crlf();
    add_negreq(NEG_TYPE_REQ, NEG_LEN_LO, 8'h01, 8'hFF);
    wrap_header();
    send_pdu(pdu_q.size());

    // good rdpNegReq without RDSTLS, trailing bytes inside the length
    pay_q.delete();
    add_cookie(CookieLen);
    pay_q.push_back(8'h80);
    add_crlf();
    add_negreq(NEG_TYPE_REQ, NEG_LEN_LO, 8'h00, 8'hFB);
    add_random(2);
    wrap_header();
    send_pdu(pdu_q.size());

    // PDU ends with a held CR
    pay_q.delete();
    add_cookie(CookieLen);
    pay_q.push_back(8'h74);
    pay_q.push_back(CHAR_CR);
    wrap_header();
    send_pdu(pdu_q.size());

    // ends inside the prefix; prefix broken early
    pay_q.delete();
    add_cookie(7);
    wrap_header();
    send_pdu(pdu_q.size());
    pay_q.delete();
    add_cookie(4);
    pay_q.push_back(8'h58);
    add_random(5);
    wrap_header();
    send_pdu(pdu_q.size());

    // restart in the middle of a token
    pay_q.delete();
    add_cookie(CookieLen);
    add_token(10);
    add_crlf();
    wrap_header();
    send_pdu(30);
    pay_q.delete();
    wrap_header();
    send_pdu(pdu_q.size());

    while (bytes_sent < StimBytes) begin
      if (rand_pdus == 8 || rand_pdus == 30) begin
        // longest PDU of the test while the receiver holds off
        hold_req = 1'b1;
        pay_q.delete();
        add_cookie(CookieLen);
        add_token(200);
        add_crlf();
        add_negreq(NEG_TYPE_REQ, NEG_LEN_LO, 8'h00, 8'($urandom));
        add_random(26);
        wrap_header();
        send_pdu(pdu_q.size());
        rand_pdus++;
      end else begin
        random_pdu();
      end
    end
    in_valid_i <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rcp_pkg.sv
rtl/rcp_front.sv
rtl/rcp_queue.sv
rtl/rcp_back.sv
rtl/rdp_connection_request_parser_top.sv
tb/rdp_connection_request_parser_checker.sv
tb/rdp_connection_request_parser_top_tb.sv
